// File: hw/rtl/lge_pkg.sv
// Shared types and constants for the life generation engine.
package lge_pkg;

    localparam int KIND_W    = 2;
    localparam int ROW_IDX_W = 5;
    localparam int CELLS_W   = 32;

    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_ADV,
        ST_POST
    } state_t;

endpackage

// File: hw/rtl/lge_req_if.sv
// Request channel: valid/ready handshake with one request payload.
interface lge_req_if;
    logic                          valid;
    logic                          ready;
    logic [lge_pkg::KIND_W-1:0]    req_type;
    logic [lge_pkg::ROW_IDX_W-1:0] row_index;
    logic [lge_pkg::CELLS_W-1:0]   row_cells;

    modport source (output valid, output req_type, output row_index, output row_cells,
                    input ready);
    modport sink   (input valid, input req_type, input row_index, input row_cells,
                    output ready);
endinterface

// File: hw/rtl/lge_rsp_if.sv
// Response channel: valid/ready handshake with one response payload.
interface lge_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lge_pkg::KIND_W-1:0]  done_kind;
    logic [lge_pkg::CELLS_W-1:0] read_cells;

    modport source (output valid, output done_kind, output read_cells, input ready);
    modport sink   (input valid, input done_kind, input read_cells, output ready);
endinterface

// File: hw/rtl/lge_bank_mem.sv
// Two-bank row store: one write port, one registered read port, per-row valid bits.
module lge_bank_mem #(
    parameter int BOARD_DIM = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [$clog2(BOARD_DIM):0]          wr_addr,
    input  logic [BOARD_DIM-1:0]                wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(BOARD_DIM):0]          rd_addr,
    output logic [BOARD_DIM-1:0]                rd_data
);
    localparam int ADDR_W = $clog2(BOARD_DIM) + 1;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic [BOARD_DIM-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [BOARD_DIM-1:0] rd_q_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // rows never written read back as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

// File: hw/rtl/lge_rule_row.sv
// B3/S23 next-state of one row from the rows above, itself and below.
module lge_rule_row #(
    parameter int BOARD_DIM = 32
) (
    input  logic [BOARD_DIM-1:0] above,
    input  logic [BOARD_DIM-1:0] mid,
    input  logic [BOARD_DIM-1:0] below,
    output logic [BOARD_DIM-1:0] next_row
);
    logic [BOARD_DIM+1:0] a_pad;
    logic [BOARD_DIM+1:0] m_pad;
    logic [BOARD_DIM+1:0] b_pad;

    // dead border on both sides
    assign a_pad = {1'b0, above, 1'b0};
    assign m_pad = {1'b0, mid, 1'b0};
    assign b_pad = {1'b0, below, 1'b0};

    always_comb
    begin
        logic [3:0] n;
        for (int c = 0; c < BOARD_DIM; c++)
        begin
            n = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
              + 4'(m_pad[c]) + 4'(m_pad[c+2])
              + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
            if (n == 4'd3)
            begin
                next_row[c] = 1'b1;
            end
            else if (n == 4'd2)
            begin
                next_row[c] = mid[c];
            end
            else
            begin
                next_row[c] = 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/life_generation_engine_core.sv
// Top level of the life generation engine: control, banks and output register.
//
// Usage:
//   req (sink) carries one request per transfer: req_type 0 writes row_index
//   of the current board with row_cells, 1 reads row_index, 2 advances one
//   generation (B3/S23, dead border). Type 3 changes nothing.
//   rsp (source) returns exactly one transfer per request: done_kind echoes
//   req_type and read_cells holds the row for a read, zero otherwise.
// Timing:
//   Write and unused requests finish in the accept cycle, a read in the cycle
//   after (registered memory port). An advance streams the current bank
//   through a three-row window, one row read per cycle, and writes the other
//   bank. One request is in work at a time.
// Stalls:
//   A finished result sits in the output register until rsp.ready; a new
//   request is taken meanwhile and its result waits in a holding register.
// Reset:
//   Bank a becomes current and every row reads as dead (per-row valid bits
//   cleared at once, no clearing pass). rsp.valid drops.
module life_generation_engine_core #(
    parameter int BOARD_DIM = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lge_req_if.sink     req,
    lge_rsp_if.source   rsp
);
    localparam int AW = $clog2(BOARD_DIM);
    localparam int CW = $clog2(BOARD_DIM + 2);

    lge_pkg::state_t state_reg, state_next;

    logic                           cur_bank_reg, cur_bank_next;
    logic [CW-1:0]                  k_reg, k_next;
    logic [BOARD_DIM-1:0]           above_reg, above_next;
    logic [BOARD_DIM-1:0]           mid_reg, mid_next;
    logic [lge_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [lge_pkg::CELLS_W-1:0]    cells_reg, cells_next;
    logic                           rd_ok_reg, rd_ok_next;

    logic                           out_valid_reg, out_valid_next;
    logic [lge_pkg::KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic [lge_pkg::CELLS_W-1:0]    out_cells_reg, out_cells_next;

    // memory port
    logic                           wr_en;
    logic [AW:0]                    wr_addr;
    logic [BOARD_DIM-1:0]           wr_data;
    logic                           rd_en;
    logic [AW:0]                    rd_addr;
    logic [BOARD_DIM-1:0]           rd_data;

    logic [BOARD_DIM-1:0]           req_row;
    logic [lge_pkg::CELLS_W-1:0]    rd_cells;
    logic [BOARD_DIM-1:0]           below;
    logic [BOARD_DIM-1:0]           gen_row;
    logic [CW-1:0]                  wr_row_idx;
    logic                           idx_ok;
    logic                           req_fire;
    logic                           out_free;
    logic                           fin;
    logic [lge_pkg::KIND_W-1:0]     fin_kind;
    logic [lge_pkg::CELLS_W-1:0]    fin_cells;

    // column width adaptation between the 32-bit fields and the board row
    for (genvar c = 0; c < BOARD_DIM; c++)
    begin : g_req_row
        if (c < lge_pkg::CELLS_W)
        begin : g_in
            assign req_row[c] = req.row_cells[c];
        end
        else
        begin : g_zero
            assign req_row[c] = 1'b0;
        end
    end

    for (genvar c = 0; c < lge_pkg::CELLS_W; c++)
    begin : g_rd_cells
        if (c < BOARD_DIM)
        begin : g_in
            assign rd_cells[c] = rd_data[c];
        end
        else
        begin : g_zero
            assign rd_cells[c] = 1'b0;
        end
    end

    lge_bank_mem #(
        .BOARD_DIM (BOARD_DIM)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // row below the one being finished; dead past the last row
    assign below = (k_reg <= CW'(BOARD_DIM)) ? rd_data : '0;

    lge_rule_row #(
        .BOARD_DIM (BOARD_DIM)
    ) u_rule (
        .above    (above_reg),
        .mid      (mid_reg),
        .below    (below),
        .next_row (gen_row)
    );

    assign wr_row_idx = k_reg - CW'(2);
    assign idx_ok     = int'(req.row_index) < BOARD_DIM;
    assign req.ready  = (state_reg == lge_pkg::ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lge_pkg::ST_IDLE;
            cur_bank_reg  <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_bank_reg  <= cur_bank_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        above_reg     <= above_next;
        mid_reg       <= mid_next;
        kind_reg      <= kind_next;
        cells_reg     <= cells_next;
        rd_ok_reg     <= rd_ok_next;
        out_kind_reg  <= out_kind_next;
        out_cells_reg <= out_cells_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_bank_next = cur_bank_reg;
        k_next        = k_reg;
        above_next    = above_reg;
        mid_next      = mid_reg;
        kind_next     = kind_reg;
        cells_next    = cells_reg;
        rd_ok_next    = rd_ok_reg;
        wr_en         = 1'b0;
        wr_addr       = {cur_bank_reg, AW'(req.row_index)};
        wr_data       = req_row;
        rd_en         = 1'b0;
        rd_addr       = {cur_bank_reg, AW'(req.row_index)};
        fin           = 1'b0;
        fin_kind      = kind_reg;
        fin_cells     = '0;

        unique case (state_reg)
            lge_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next = req.req_type;
                    fin_kind  = req.req_type;
                    case (req.req_type)
                        lge_pkg::KIND_WRITE:
                        begin
                            wr_en = idx_ok;
                            fin   = 1'b1;
                        end
                        lge_pkg::KIND_READ:
                        begin
                            rd_en      = idx_ok;
                            rd_ok_next = idx_ok;
                            state_next = lge_pkg::ST_RDWAIT;
                        end
                        lge_pkg::KIND_ADVANCE:
                        begin
                            k_next     = '0;
                            above_next = '0;
                            mid_next   = '0;
                            state_next = lge_pkg::ST_ADV;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            lge_pkg::ST_RDWAIT:
            begin
                fin       = 1'b1;
                fin_cells = rd_ok_reg ? rd_cells : '0;
            end
            lge_pkg::ST_ADV:
            begin
                // issue row k, receive row k-1, retire row k-2
                rd_en   = (k_reg < CW'(BOARD_DIM));
                rd_addr = {cur_bank_reg, k_reg[AW-1:0]};
                wr_en   = (k_reg >= CW'(2));
                wr_addr = {~cur_bank_reg, wr_row_idx[AW-1:0]};
                wr_data = gen_row;
                if ((k_reg >= CW'(1)) && (k_reg <= CW'(BOARD_DIM)))
                begin
                    above_next = mid_reg;
                    mid_next   = rd_data;
                end
                if (k_reg == CW'(BOARD_DIM + 1))
                begin
                    cur_bank_next = ~cur_bank_reg;
                    fin           = 1'b1;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                end
            end
            lge_pkg::ST_POST:
            begin
                fin       = 1'b1;
                fin_cells = cells_reg;
            end
            default:
            begin
                state_next = lge_pkg::ST_IDLE;
            end
        endcase

        // hand the result to the output register, or park it
        if (fin)
        begin
            if (out_free)
            begin
                state_next = lge_pkg::ST_IDLE;
            end
            else
            begin
                cells_next = fin_cells;
                state_next = lge_pkg::ST_POST;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_cells_next = out_cells_reg;
        if (fin && out_free)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = fin_kind;
            out_cells_next = fin_cells;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.done_kind  = out_kind_reg;
    assign rsp.read_cells = out_cells_reg;

    // no request taken while one is in work
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lge_pkg::ST_IDLE) |-> !req.ready)
        else $error("request accepted while busy");

    // an advance never reads and writes the same row entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same entry");

    // the current bank flips exactly when an advance ends
    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_bank_reg != $past(cur_bank_reg)) |->
            ($past(state_reg) == lge_pkg::ST_ADV) && (state_reg != lge_pkg::ST_ADV))
        else $error("bank flip outside advance end");

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> $stable(out_cells_reg) && $stable(out_kind_reg))
        else $error("pending result overwritten");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the life generation engine: board predictor and reply scoreboard.
`timescale 1ns / 1ps

module testbench;

    // Board edge; matches the core parameter that is passed in below.
    localparam int BOARD = 32;

    typedef logic [lge_pkg::KIND_W-1:0]    kind_t;
    typedef logic [lge_pkg::ROW_IDX_W-1:0] row_idx_t;
    typedef logic [lge_pkg::CELLS_W-1:0]   cells_t;

    // Request type 3 is not decoded by the core; it must just be echoed.
    localparam kind_t KIND_UNUSED = 2'd3;

    // Row bits that survive a write.
    localparam cells_t COL_MASK = {lge_pkg::CELLS_W{1'b1}} >> (lge_pkg::CELLS_W - BOARD);

    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_PCT     = 17;
    // Long receiver hold-off: starts once this many replies have gone by.
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 80;
    // Window with no idling on either side, counted in random-part requests.
    localparam int QUIET_FROM   = 150;
    localparam int QUIET_TO     = 250;
    // Run-on time after the last reply, long enough to cover an advance.
    localparam int DRAIN_CYCLES = BOARD + 8;

    typedef struct packed {
        kind_t  kind;
        cells_t cells;
    } reply_t;

    // Tracks both banks, the current bank and the replies still owed by the core.
    class life_board_checker;
        cells_t      rows [2][BOARD];
        bit          cur;
        reply_t      owed [$];
        int unsigned fail_count;

        function new();
            for (int b = 0; b < 2; b++)
                for (int r = 0; r < BOARD; r++)
                    rows[b][r] = '0;
            cur        = 1'b0;
            fail_count = 0;
        endfunction

        // Off-board cells are dead: no wrap-around.
        function int unsigned live_at(int r, int c);
            if (r < 0 || r >= BOARD || c < 0 || c >= BOARD)
                return 0;
            return int'(rows[cur][r][c]);
        endfunction

        // B3/S23 into the other bank, which then becomes current.
        function void step_generation();
            int unsigned n;
            cells_t      nxt;
            for (int r = 0; r < BOARD; r++)
            begin
                nxt = '0;
                for (int c = 0; c < BOARD; c++)
                begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0)
                                n += live_at(r + dr, c + dc);
                    if (n == 3)
                        nxt[c] = 1'b1;
                    else if (n == 2)
                        nxt[c] = rows[cur][r][c];
                end
                rows[~cur][r] = nxt;
            end
            cur = ~cur;
        endfunction

        function void note_request(kind_t kind, row_idx_t idx, cells_t cells);
            reply_t want;
            want.kind  = kind;
            want.cells = '0;
            case (kind)
                lge_pkg::KIND_WRITE:   if (idx < BOARD) rows[cur][idx] = cells & COL_MASK;
                lge_pkg::KIND_READ:    if (idx < BOARD) want.cells = rows[cur][idx];
                lge_pkg::KIND_ADVANCE: step_generation();
                default:               ;
            endcase
            owed.push_back(want);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            fail_count++;
        endtask

        task check_reply(kind_t kind, cells_t cells);
            reply_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("reply with nothing outstanding: kind %0d cells %h",
                                 kind, cells));
                return;
            end
            want = owed.pop_front();
            if (kind !== want.kind)
                report($sformatf("done_kind %0d, want %0d", kind, want.kind));
            if (cells !== want.cells)
                report($sformatf("read_cells %h, want %h (kind %0d)", cells, want.cells,
                                 want.kind));
        endtask

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lge_req_if req_ch ();
    lge_rsp_if rsp_ch ();

    life_board_checker board;

    // quiet: no idling on either side.
    bit          quiet        = 1'b0;
    int unsigned replies_seen = 0;
    int unsigned items_sent   = 0;

    life_generation_engine_core #(
        .BOARD_DIM (BOARD)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request; called and returning at a falling edge. Valid stays
    // high into the next call so back-to-back transfers are possible.
    task automatic send_request(input kind_t kind,
                                input row_idx_t idx,
                                input cells_t cells);
        if (!quiet)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req_ch.valid = 1'b0;
                @(negedge clk);
            end
        req_ch.valid     = 1'b1;
        req_ch.req_type  = kind;
        req_ch.row_index = idx;
        req_ch.row_cells = cells;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(kind, idx, cells);
        items_sent++;
        @(negedge clk);
    endtask

    // Row content with a random density so that generations neither die out
    // at once nor saturate.
    function automatic cells_t random_row();
        case ($urandom_range(2))
            0:       return $urandom();
            1:       return $urandom() & $urandom();
            default: return $urandom() | $urandom();
        endcase
    endfunction

    // A well-formed run: seed a few rows, then advance and sample rows.
    task automatic seed_and_evolve();
        int unsigned seeds;
        int unsigned gens;
        seeds = $urandom_range(8, 1);
        gens  = $urandom_range(3, 1);
        repeat (seeds)
            send_request(lge_pkg::KIND_WRITE, row_idx_t'($urandom_range(BOARD - 1)),
                         random_row());
        repeat (gens)
        begin
            send_request(lge_pkg::KIND_ADVANCE, row_idx_t'($urandom()), $urandom());
            repeat ($urandom_range(4, 1))
                send_request(lge_pkg::KIND_READ, row_idx_t'($urandom_range(BOARD - 1)),
                             $urandom());
        end
    endtask

    // Consecutive readback of a band of rows.
    task automatic read_band();
        int unsigned first;
        first = $urandom_range(BOARD - 8);
        for (int i = 0; i < 8; i++)
            send_request(lge_pkg::KIND_READ, row_idx_t'(first + i), $urandom());
    endtask

    // Reply monitor: every transfer on the response side is checked.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            board.check_reply(rsp_ch.done_kind, rsp_ch.read_cells);
            replies_seen++;
        end
    end

    // Receiver: random stalls, none in the quiet window, and one long
    // hold-off so the output and holding registers fill and req.ready drops.
    initial
    begin
        bit held;
        held         = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && replies_seen >= HOLD_AT)
            begin
                held         = 1'b1;
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ch.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Guard against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int unsigned random_base;
        int unsigned pick;

        board            = new();
        req_ch.valid     = 1'b0;
        req_ch.req_type  = lge_pkg::KIND_WRITE;
        req_ch.row_index = '0;
        req_ch.row_cells = '0;
        rst_n            = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset contents, edge rows, full and empty rows, the
        // unused request type, and a blinker against the right edge.
        send_request(lge_pkg::KIND_READ, 5'd0, '0);
        send_request(lge_pkg::KIND_READ, 5'd31, '1);
        send_request(lge_pkg::KIND_WRITE, 5'd0, 32'hFFFF_FFFF);
        send_request(lge_pkg::KIND_WRITE, 5'd31, 32'h8000_0001);
        send_request(lge_pkg::KIND_WRITE, 5'd15, 32'hAAAA_5555);
        send_request(lge_pkg::KIND_READ, 5'd0, '0);
        send_request(lge_pkg::KIND_READ, 5'd31, '0);
        send_request(lge_pkg::KIND_READ, 5'd15, '0);
        // Unused type must leave the board alone.
        send_request(KIND_UNUSED, 5'd31, 32'hFFFF_FFFF);
        send_request(lge_pkg::KIND_READ, 5'd0, '0);
        send_request(lge_pkg::KIND_ADVANCE, 5'd0, '0);
        send_request(lge_pkg::KIND_READ, 5'd0, '0);
        send_request(lge_pkg::KIND_READ, 5'd1, '0);
        send_request(lge_pkg::KIND_READ, 5'd31, '0);
        send_request(lge_pkg::KIND_WRITE, 5'd20, 32'h8000_0000);
        send_request(lge_pkg::KIND_WRITE, 5'd21, 32'h8000_0000);
        send_request(lge_pkg::KIND_WRITE, 5'd22, 32'h8000_0000);
        send_request(lge_pkg::KIND_WRITE, 5'd15, 32'h0000_0000);
        // Row and cells on an advance must not matter.
        send_request(lge_pkg::KIND_ADVANCE, 5'd21, 32'hFFFF_FFFF);
        send_request(lge_pkg::KIND_READ, 5'd21, '0);
        send_request(lge_pkg::KIND_READ, 5'd20, '0);
        send_request(lge_pkg::KIND_ADVANCE, 5'd31, 32'h0000_0000);
        send_request(lge_pkg::KIND_READ, 5'd21, '0);
        send_request(lge_pkg::KIND_READ, 5'd22, '0);

        // Random part: mostly seeded runs of generations, some band
        // readbacks, the rest single arbitrary requests.
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            quiet = (items_sent - random_base >= QUIET_FROM) &&
                    (items_sent - random_base < QUIET_TO);
            pick = $urandom_range(99);
            if (pick < 70)
                seed_and_evolve();
            else if (pick < 80)
                read_band();
            else
                send_request(kind_t'($urandom_range(3)), row_idx_t'($urandom()),
                             $urandom());
        end

        req_ch.valid = 1'b0;
        quiet        = 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/lge_pkg.sv
hw/rtl/lge_req_if.sv
hw/rtl/lge_rsp_if.sv
hw/rtl/lge_bank_mem.sv
hw/rtl/lge_rule_row.sv
hw/rtl/life_generation_engine_core.sv
tb/sv/testbench.sv
